>>> design/background_subtract_run_blob_segmenter_core_assert.svh
// ---------------------------------------------------------------------------
// bsrb assertion macros
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef BACKGROUND_SUBTRACT_RUN_BLOB_SEGMENTER_CORE_ASSERT_SVH
`define BACKGROUND_SUBTRACT_RUN_BLOB_SEGMENTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge outside reset
`define BSRB_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("bsrb assertion failed");

// same-cycle implication
`define BSRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsrb assertion failed");

// next-cycle implication
`define BSRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsrb assertion failed");

`else

`define BSRB_ASSERT_ALWAYS(label, clk, rst, cond)
`define BSRB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BSRB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/bsrb_pkg.sv
// ---------------------------------------------------------------------------
// bsrb package
// shared types, register codes and grey conversion for the segmenter
// ---------------------------------------------------------------------------
`default_nettype none

package bsrb_pkg;

   localparam int PIX_W      = 8;
   localparam int POS_OUT_W  = 10;
   localparam int BLOB_OUT_W = 8;
   localparam int CFG_SIZE_W = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;

   localparam int DEF_MAX_COLS  = 1024;
   localparam int DEF_MAX_ROWS  = 1024;
   localparam int DEF_MAX_BLOBS = 256;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT      = 2'd2;

   // register reset values
   localparam logic [PIX_W-1:0]      RST_DIFF_THRESHOLD = 8'd70;
   localparam logic [CFG_SIZE_W-1:0] RST_COLUMN_COUNT   = 11'd1024;
   localparam logic [CFG_SIZE_W-1:0] RST_ROW_COUNT      = 11'd1024;

   typedef struct packed {
      logic [PIX_W-1:0] bg_red;
      logic [PIX_W-1:0] bg_green;
      logic [PIX_W-1:0] bg_blue;
      logic [PIX_W-1:0] frame_red;
      logic [PIX_W-1:0] frame_green;
      logic [PIX_W-1:0] frame_blue;
   } pixel_pair_type;

   typedef struct packed {
      logic                  foreground;
      logic                  segment_valid;
      logic [POS_OUT_W-1:0]  segment_row;
      logic [POS_OUT_W-1:0]  segment_left;
      logic [POS_OUT_W-1:0]  segment_right;
      logic [BLOB_OUT_W-1:0] blob_index;
      logic                  blob_overflow;
      logic                  frame_end;
   } segment_type;

   // (r+g+b)/3 truncated: reciprocal 683/2048 is exact for sums up to 765
   function automatic logic [PIX_W-1:0] grey_of(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
      logic [9:0]  sum;
      logic [19:0] prod;
      sum  = 10'(r) + 10'(g) + 10'(b);
      prod = 20'(sum) * 20'd683;
      return prod[18:11];
   endfunction

endpackage

`default_nettype wire

>>> design/bsrb_if.sv
// ---------------------------------------------------------------------------
// bsrb stream interfaces
// valid/ready channels for pixel pairs in and segment results out
// ---------------------------------------------------------------------------
`default_nettype none

interface bsrb_req_if;
   import bsrb_pkg::*;

   logic           valid;
   logic           ready;
   pixel_pair_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bsrb_rsp_if;
   import bsrb_pkg::*;

   logic        valid;
   logic        ready;
   segment_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/background_subtract_run_blob_segmenter_core.sv
// ---------------------------------------------------------------------------
// background subtract run blob segmenter core
// path: req transfer into the grey stage register, then the result register
// throughput: one pixel per cycle unless rsp stalls, set by grey/run stages
// reset: synchronous, clears valids, positions, run and blob state, registers
// ---------------------------------------------------------------------------
`default_nettype none

`include "background_subtract_run_blob_segmenter_core_assert.svh"

module background_subtract_run_blob_segmenter_core #(
   parameter int MAX_COLS  = bsrb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS  = bsrb_pkg::DEF_MAX_ROWS,
   parameter int MAX_BLOBS = bsrb_pkg::DEF_MAX_BLOBS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bsrb_req_if.sink                            req_if,
   bsrb_rsp_if.source                          rsp_if,
   input  wire logic                           csr_wr_en,
   input  wire logic [bsrb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bsrb_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import bsrb_pkg::*;

   // position and count widths follow the size limits
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int BLOB_W = $clog2(MAX_BLOBS + 1);
   // width wide enough for both the size registers and the limits
   localparam int CSZ_W  = ($clog2(MAX_COLS + 1) > CFG_SIZE_W) ?
                           $clog2(MAX_COLS + 1) : CFG_SIZE_W;
   localparam int RSZ_W  = ($clog2(MAX_ROWS + 1) > CFG_SIZE_W) ?
                           $clog2(MAX_ROWS + 1) : CFG_SIZE_W;

   localparam logic [CSZ_W-1:0]  COL_LIMIT  = CSZ_W'(MAX_COLS);
   localparam logic [RSZ_W-1:0]  ROW_LIMIT  = RSZ_W'(MAX_ROWS);
   localparam logic [BLOB_W-1:0] BLOB_LIMIT = BLOB_W'(MAX_BLOBS);

   // configuration registers
   logic [PIX_W-1:0]      diff_threshold_ff;
   logic [CFG_SIZE_W-1:0] column_count_ff;
   logic [CFG_SIZE_W-1:0] row_count_ff;

   // grey stage (input register)
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_grey_bg_ff, s1_grey_fr_ff;

   // run / blob state
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              run_open_ff, run_open_in;
   logic [COL_W-1:0]  run_start_ff, run_start_in;
   logic [BLOB_W-1:0] blob_cnt_ff, blob_cnt_in;
   logic [ROW_W-1:0]  last_seg_row_ff, last_seg_row_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   segment_type rsp_data_ff, rsp_data_in;

   // handshake
   logic s2_free;
   logic s1_adv;
   logic req_xfer;

   // run stage logic
   logic [PIX_W-1:0]  grey_diff;
   logic              fg;
   logic [CSZ_W-1:0]  cols_eff;
   logic [RSZ_W-1:0]  rows_eff;
   logic              last_col;
   logic              last_row;
   logic              open_now;
   logic [COL_W-1:0]  start_now;
   logic              seg;
   logic [COL_W-1:0]  seg_right;
   logic              new_blob;
   logic              blob_full;
   logic              ovf;
   logic [BLOB_W-1:0] blob_cnt_next;
   logic [BLOB_W-1:0] blob_idx;

   // result slot frees when empty or when its transfer happens this cycle
   assign s2_free       = !rsp_valid_ff || rsp_if.ready;
   assign s1_adv        = s1_valid_ff && s2_free;
   assign req_if.ready  = !s1_valid_ff || s2_free;
   assign req_xfer      = req_if.valid && req_if.ready;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_threshold_ff <= RST_DIFF_THRESHOLD;
         column_count_ff   <= RST_COLUMN_COUNT;
         row_count_ff      <= RST_ROW_COUNT;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DIFF_THRESHOLD: diff_threshold_ff <= csr_wr_data[PIX_W-1:0];
            CSR_COLUMN_COUNT:   column_count_ff   <= csr_wr_data[CFG_SIZE_W-1:0];
            CSR_ROW_COUNT:      row_count_ff      <= csr_wr_data[CFG_SIZE_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // grey stage: both pixels reduced to grey on the way in
   assign s1_valid_in = req_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_grey_bg_ff <= grey_of(req_if.payload.bg_red, req_if.payload.bg_green,
                                  req_if.payload.bg_blue);
         s1_grey_fr_ff <= grey_of(req_if.payload.frame_red, req_if.payload.frame_green,
                                  req_if.payload.frame_blue);
      end
   end

   // run stage
   always_comb begin
      // foreground decision
      grey_diff = (s1_grey_bg_ff > s1_grey_fr_ff) ? (s1_grey_bg_ff - s1_grey_fr_ff)
                                                  : (s1_grey_fr_ff - s1_grey_bg_ff);
      fg        = grey_diff >= diff_threshold_ff;

      // effective frame size, zero acts as one, clipped to the limits
      if (column_count_ff == '0) begin
         cols_eff = CSZ_W'(1);
      end else if (CSZ_W'(column_count_ff) > COL_LIMIT) begin
         cols_eff = COL_LIMIT;
      end else begin
         cols_eff = CSZ_W'(column_count_ff);
      end
      if (row_count_ff == '0) begin
         rows_eff = RSZ_W'(1);
      end else if (RSZ_W'(row_count_ff) > ROW_LIMIT) begin
         rows_eff = ROW_LIMIT;
      end else begin
         rows_eff = RSZ_W'(row_count_ff);
      end
      last_col = CSZ_W'(col_ff) >= (cols_eff - CSZ_W'(1));
      last_row = RSZ_W'(row_ff) >= (rows_eff - RSZ_W'(1));

      // run tracking: a run closes on a background pixel or at row end
      open_now  = run_open_ff || fg;
      start_now = run_open_ff ? run_start_ff : col_ff;
      seg       = open_now && (!fg || last_col);
      seg_right = fg ? col_ff : (col_ff - COL_W'(1));

      // blob assignment: first run or gap of more than one row starts a new blob
      new_blob  = (blob_cnt_ff == '0) ||
                  ({1'b0, row_ff} > ({1'b0, last_seg_row_ff} + (ROW_W + 1)'(1)));
      blob_full = blob_cnt_ff == BLOB_LIMIT;
      ovf       = seg && new_blob && blob_full;
      blob_cnt_next = (seg && new_blob && !blob_full) ? (blob_cnt_ff + BLOB_W'(1))
                                                      : blob_cnt_ff;
      blob_idx  = blob_cnt_next - BLOB_W'(1);

      // result, segment fields zero when no run closed
      rsp_data_in.foreground    = fg;
      rsp_data_in.segment_valid = seg;
      rsp_data_in.segment_row   = seg ? POS_OUT_W'(row_ff) : '0;
      rsp_data_in.segment_left  = seg ? POS_OUT_W'(start_now) : '0;
      rsp_data_in.segment_right = seg ? POS_OUT_W'(seg_right) : '0;
      rsp_data_in.blob_index    = seg ? BLOB_OUT_W'(blob_idx) : '0;
      rsp_data_in.blob_overflow = ovf;
      rsp_data_in.frame_end     = last_col && last_row;

      // next state
      col_in          = col_ff;
      row_in          = row_ff;
      run_open_in     = run_open_ff;
      run_start_in    = run_start_ff;
      blob_cnt_in     = blob_cnt_ff;
      last_seg_row_in = last_seg_row_ff;
      if (s1_adv) begin
         run_start_in    = start_now;
         blob_cnt_in     = blob_cnt_next;
         last_seg_row_in = seg ? row_ff : last_seg_row_ff;
         if (last_col) begin
            col_in      = '0;
            run_open_in = 1'b0;
            if (last_row) begin
               // frame end, counts start over
               row_in          = '0;
               blob_cnt_in     = '0;
               last_seg_row_in = '0;
               run_start_in    = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in      = col_ff + COL_W'(1);
            run_open_in = open_now && !seg;
         end
      end

      // result register hand-off
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff          <= '0;
         row_ff          <= '0;
         run_open_ff     <= 1'b0;
         run_start_ff    <= '0;
         blob_cnt_ff     <= '0;
         last_seg_row_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         col_ff          <= col_in;
         row_ff          <= row_in;
         run_open_ff     <= run_open_in;
         run_start_ff    <= run_start_in;
         blob_cnt_ff     <= blob_cnt_in;
         last_seg_row_ff <= last_seg_row_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, loaded with each transfer out of the run stage
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // segment fields stay clear on results without a finished run
   `BSRB_ASSERT_IMPL(a_no_seg_zero, clock, reset,
      rsp_valid_ff && !rsp_data_ff.segment_valid,
      rsp_data_ff.segment_row == '0 && rsp_data_ff.segment_left == '0 &&
      rsp_data_ff.segment_right == '0 && rsp_data_ff.blob_index == '0 &&
      !rsp_data_ff.blob_overflow)

   // a finished run never ends left of its start
   `BSRB_ASSERT_IMPL(a_seg_order, clock, reset,
      rsp_valid_ff && rsp_data_ff.segment_valid,
      rsp_data_ff.segment_left <= rsp_data_ff.segment_right)

   // overflow only flagged on a segment
   `BSRB_ASSERT_IMPL(a_ovf_needs_seg, clock, reset,
      rsp_valid_ff && rsp_data_ff.blob_overflow,
      rsp_data_ff.segment_valid)

   // last pixel of a frame clears positions and blob count
   `BSRB_ASSERT_NEXT(a_frame_wrap, clock, reset,
      s1_adv && last_col && last_row,
      col_ff == '0 && row_ff == '0 && blob_cnt_ff == '0 && !run_open_ff)

   // blob count saturates at the limit
   `BSRB_ASSERT_ALWAYS(a_blob_cnt_range, clock, reset,
      blob_cnt_ff <= BLOB_LIMIT)

endmodule

`default_nettype wire

>>> bench/bsrb_segment_checker.sv
// ---------------------------------------------------------------------------
// bsrb segment checker
// watches the pixel, result and register ports of the segmenter, predicts
// each result from its own copy of the run and blob state, and compares
// ---------------------------------------------------------------------------
module bsrb_segment_checker #(
   parameter int MAX_COLS  = bsrb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS  = bsrb_pkg::DEF_MAX_ROWS,
   parameter int MAX_BLOBS = bsrb_pkg::DEF_MAX_BLOBS
) (
   input  logic                           clock,
   input  logic                           reset,
   bsrb_req_if                            req_mon,
   bsrb_rsp_if                            rsp_mon,
   input  logic                           csr_wr_en,
   input  logic [bsrb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsrb_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                             check_failures,
   output int                             results_pending,
   output int                             segments_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import bsrb_pkg::*;

   // register copies
   logic [PIX_W-1:0]      thresh;
   logic [CFG_SIZE_W-1:0] width_cfg;
   logic [CFG_SIZE_W-1:0] height_cfg;

   // scan and blob state
   int unsigned col_at;
   int unsigned row_at;
   bit          run_live;
   int unsigned run_first;
   int unsigned blobs_seen;
   int unsigned prev_seg_row;

   segment_type expected_segments[$];
   segment_type predicted;
   segment_type wanted;
   int          fail_count = 0;
   int          seg_count  = 0;

   assign check_failures   = fail_count;
   assign segments_checked = seg_count;
   assign results_pending  = expected_segments.size();

   function automatic int unsigned grey3(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                         logic [PIX_W-1:0] b);
      return (int'(r) + int'(g) + int'(b)) / 3;
   endfunction

   function automatic int unsigned clamp_dim(logic [CFG_SIZE_W-1:0] v, int unsigned lim);
      if (v == '0) return 1;
      if (int'(v) > lim) return lim;
      return 32'(v);
   endfunction

   // one pixel pair in, one segment record out; advances the scan state
   task automatic advance_scan(input pixel_pair_type p, output segment_type s);
      int unsigned cols;
      int unsigned rows;
      int unsigned gb;
      int unsigned gf;
      int unsigned gap;
      bit          fg;
      bit          last_col;
      bit          last_row;
      bit          seg;
      bit          ovf;
      int unsigned left;
      int unsigned right;
      int unsigned idx;
      cols     = clamp_dim(width_cfg, MAX_COLS);
      rows     = clamp_dim(height_cfg, MAX_ROWS);
      gb       = grey3(p.bg_red, p.bg_green, p.bg_blue);
      gf       = grey3(p.frame_red, p.frame_green, p.frame_blue);
      gap      = (gb > gf) ? gb - gf : gf - gb;
      fg       = gap >= thresh;
      last_col = col_at >= cols - 1;
      last_row = row_at >= rows - 1;
      seg      = 1'b0;
      ovf      = 1'b0;
      left     = 0;
      right    = 0;
      idx      = 0;

      if (fg && !run_live) begin
         run_live  = 1'b1;
         run_first = col_at;
      end
      if (run_live && !fg) begin
         seg   = 1'b1;
         left  = run_first;
         right = col_at - 1;
      end else if (run_live && last_col) begin
         seg   = 1'b1;
         left  = run_first;
         right = col_at;
      end
      if (seg) begin
         run_live = 1'b0;
         // unsigned row distance, same wrap as a 32-bit counter
         if (blobs_seen == 0 || row_at - prev_seg_row > 1) begin
            if (blobs_seen < MAX_BLOBS) blobs_seen++;
            else ovf = 1'b1;
         end
         idx          = blobs_seen - 1;
         prev_seg_row = row_at;
      end

      s               = '0;
      s.foreground    = fg;
      s.segment_valid = seg;
      s.segment_row   = seg ? POS_OUT_W'(row_at) : '0;
      s.segment_left  = POS_OUT_W'(left);
      s.segment_right = POS_OUT_W'(right);
      s.blob_index    = BLOB_OUT_W'(idx);
      s.blob_overflow = ovf;
      s.frame_end     = last_col && last_row;

      if (last_col) begin
         col_at   = 0;
         run_live = 1'b0;
         if (last_row) begin
            row_at       = 0;
            blobs_seen   = 0;
            prev_seg_row = 0;
            run_first    = 0;
         end else begin
            row_at++;
         end
      end else begin
         col_at++;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         thresh       = RST_DIFF_THRESHOLD;
         width_cfg    = RST_COLUMN_COUNT;
         height_cfg   = RST_ROW_COUNT;
         col_at       = 0;
         row_at       = 0;
         run_live     = 1'b0;
         run_first    = 0;
         blobs_seen   = 0;
         prev_seg_row = 0;
         expected_segments.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DIFF_THRESHOLD: thresh = csr_wr_data[PIX_W-1:0];
               CSR_COLUMN_COUNT:   width_cfg = csr_wr_data;
               CSR_ROW_COUNT:      height_cfg = csr_wr_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_scan(req_mon.payload, predicted);
            expected_segments.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_segments.size() == 0) begin
               $error("result transfer with no pixel waiting for it");
               fail_count++;
            end else begin
               wanted = expected_segments.pop_front();
               check_field("foreground", 32'(wanted.foreground),
                           32'(rsp_mon.payload.foreground));
               check_field("segment_valid", 32'(wanted.segment_valid),
                           32'(rsp_mon.payload.segment_valid));
               check_field("segment_row", 32'(wanted.segment_row),
                           32'(rsp_mon.payload.segment_row));
               check_field("segment_left", 32'(wanted.segment_left),
                           32'(rsp_mon.payload.segment_left));
               check_field("segment_right", 32'(wanted.segment_right),
                           32'(rsp_mon.payload.segment_right));
               check_field("blob_index", 32'(wanted.blob_index),
                           32'(rsp_mon.payload.blob_index));
               check_field("blob_overflow", 32'(wanted.blob_overflow),
                           32'(rsp_mon.payload.blob_overflow));
               check_field("frame_end", 32'(wanted.frame_end),
                           32'(rsp_mon.payload.frame_end));
               if (wanted.segment_valid) seg_count++;
            end
         end
      end
   end

endmodule

>>> bench/tb_background_subtract_run_blob_segmenter_core.sv
// ---------------------------------------------------------------------------
// segmenter core testbench
// drives pixel pairs and register writes into the segmenter, with random
// stalls on both channels; a side checker predicts and compares every result
// ---------------------------------------------------------------------------
module tb_background_subtract_run_blob_segmenter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bsrb_pkg::*;

   localparam int CLOCK_HIGH_NS     = 4;
   localparam int CLOCK_LOW_NS      = 4;
   localparam int RESET_CYCLES      = 5;
   localparam int CYCLE_LIMIT       = 400000;
   localparam int LONG_HOLD_CYCLES  = 160;
   localparam int DRAIN_CYCLES      = 8;
   localparam int MAX_GAP           = 18;
   localparam int BLOB_ROW_PIXELS   = 160;
   localparam int RANDOM_SETTINGS   = 6;
   localparam int PIXELS_PER_SET    = 36;
   localparam int DIRECTED_PIXELS   = 20;

   // index past the register list, must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   bsrb_req_if req_if ();
   bsrb_rsp_if rsp_if ();

   int check_failures;
   int results_pending;
   int segments_checked;

   // stimulus knobs, set per phase by the main sequence
   int               sender_gap_pct = 0;
   int               rsp_stall_pct  = 0;
   bit               long_hold_req  = 1'b0;
   logic [PIX_W-1:0] cur_threshold  = RST_DIFF_THRESHOLD;
   int               pixels_sent    = 0;
   int               settings_used  = 0;
   int               cycle_count    = 0;

   // directed frame, 4 columns by 5 rows, uniform grey pixels (bg, frame)
   // row 0: two-pixel run from column 0, then a run at the last column
   //        whose difference sits exactly on the threshold
   // row 1: one below the threshold, nothing foreground
   // row 2: run of one at column 0, two rows below: a new blob
   // row 3: run that ends on the last column
   // row 4: full-row run and the end of the frame
   logic [PIX_W-1:0] dir_bg_grey [DIRECTED_PIXELS] = '{
      8'd0,   8'd255, 8'd10,  8'd0,
      8'd100, 8'd5,   8'd255, 8'd0,
      8'd30,  8'd200, 8'd1,   8'd50,
      8'd9,   8'd77,  8'd255, 8'd0,
      8'd0,   8'd128, 8'd0,   8'd255
   };
   logic [PIX_W-1:0] dir_frame_grey [DIRECTED_PIXELS] = '{
      8'd255, 8'd0,   8'd10,  8'd70,
      8'd169, 8'd5,   8'd255, 8'd0,
      8'd100, 8'd200, 8'd2,   8'd50,
      8'd9,   8'd77,  8'd185, 8'd200,
      8'd255, 8'd0,   8'd128, 8'd0
   };

   background_subtract_run_blob_segmenter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   bsrb_segment_checker u_segment_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .check_failures   (check_failures),
      .results_pending  (results_pending),
      .segments_checked (segments_checked)
   );

   always begin
      #(CLOCK_LOW_NS) clock = 1'b1;
      #(CLOCK_HIGH_NS) clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_background_subtract_run_blob_segmenter_core: done, errors");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         if (long_hold_req) begin
            // hold long enough for the pipe to fill and back up the input
            rsp_if.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_req = 1'b0;
         end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   function automatic int unsigned grey_gap(pixel_pair_type p);
      int unsigned gb;
      int unsigned gf;
      gb = (int'(p.bg_red) + int'(p.bg_green) + int'(p.bg_blue)) / 3;
      gf = (int'(p.frame_red) + int'(p.frame_green) + int'(p.frame_blue)) / 3;
      return (gb > gf) ? gb - gf : gf - gb;
   endfunction

   function automatic pixel_pair_type rand_pixel();
      pixel_pair_type p;
      p.bg_red      = 8'($urandom_range(0, 255));
      p.bg_green    = 8'($urandom_range(0, 255));
      p.bg_blue     = 8'($urandom_range(0, 255));
      p.frame_red   = 8'($urandom_range(0, 255));
      p.frame_green = 8'($urandom_range(0, 255));
      p.frame_blue  = 8'($urandom_range(0, 255));
      return p;
   endfunction

   function automatic pixel_pair_type grey_pair(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      return '{a, a, a, b, b, b};
   endfunction

   // random colors that land on the wanted side of the threshold
   function automatic pixel_pair_type make_pixel(bit want_fg);
      pixel_pair_type p;
      for (int i = 0; i < 8; i++) begin
         p = rand_pixel();
         if ((grey_gap(p) >= cur_threshold) == want_fg) return p;
      end
      // fall back to a full-swing pair, or a frame equal to the background
      if (want_fg) p = $urandom_range(0, 1) ? grey_pair(8'd0, 8'd255) : grey_pair(8'd255, 8'd0);
      else p.frame_red = p.bg_red;
      if (!want_fg) begin
         p.frame_green = p.bg_green;
         p.frame_blue  = p.bg_blue;
      end
      return p;
   endfunction

   // called and returns at a falling edge; valid stays high between back-to-back pixels
   task automatic send_pixel(input pixel_pair_type p);
      if (sender_gap_pct != 0 && $urandom_range(1, 100) <= sender_gap_pct) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(negedge clock);
      end
      req_if.payload = p;
      req_if.valid   = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index   = idx;
      csr_wr_data = data;
      csr_wr_en   = 1'b1;
      if (idx == CSR_DIFF_THRESHOLD) cur_threshold = data[PIX_W-1:0];
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] thr,
                                input logic [CSR_DATA_W-1:0] cols,
                                input logic [CSR_DATA_W-1:0] rows);
      write_reg(CSR_DIFF_THRESHOLD, thr);
      write_reg(CSR_COLUMN_COUNT, cols);
      write_reg(CSR_ROW_COUNT, rows);
      settings_used++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      req_if.valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      bit             run_fg;
      pixel_pair_type pix;
      logic [CSR_DATA_W-1:0] thr;
      logic [CSR_DATA_W-1:0] cols;
      logic [CSR_DATA_W-1:0] rows;

      req_if.valid   = 1'b0;
      req_if.payload = '0;
      run_fg         = 1'b0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // directed frame at the default threshold, moderate stalls
      sender_gap_pct = 20;
      rsp_stall_pct  = 20;
      apply_setting(11'd70, 11'd4, 11'd5);
      for (int i = 0; i < DIRECTED_PIXELS; i++)
         send_pixel(grey_pair(dir_bg_grey[i], dir_frame_grey[i]));
      drain();

      // zero threshold, zero sizes: every pixel is foreground, each one a frame
      apply_setting(11'd0, 11'd0, 11'd0);
      for (int i = 0; i < 3; i++) send_pixel(rand_pixel());
      drain();

      // top threshold and oversize dimensions clamp to the maximum frame
      apply_setting(11'd255, 11'h7FF, 11'h7FF);
      send_pixel(grey_pair(8'd0, 8'd255));
      send_pixel(grey_pair(8'd255, 8'd0));
      send_pixel(grey_pair(8'd0, 8'd254));
      send_pixel(grey_pair(8'd255, 8'd255));
      drain();
      write_reg(CSR_UNMAPPED, 11'($urandom));

      // one pixel per row, foreground on every other row: each run after the
      // first opens a new blob; also shrinks the size mid-frame
      apply_setting(11'd70, 11'd1, 11'd1024);
      sender_gap_pct = 0;
      long_hold_req  = 1'b1;
      for (int i = 0; i < BLOB_ROW_PIXELS; i++) begin
         if (i == 80) begin
            sender_gap_pct = 15;
            rsp_stall_pct  = 15;
         end
         send_pixel(make_pixel(i % 2 == 0));
      end
      drain();

      // random settings, runs built from a two-state walk plus noise
      for (int k = 0; k < RANDOM_SETTINGS; k++) begin
         case (k)
            0: begin thr = 11'd1;   cols = 11'd3;    rows = 11'd2;    end
            1: begin thr = 11'd255; cols = 11'd1024; rows = 11'd1024; end
            2: begin thr  = 11'($urandom_range(0, 255));
                     cols = 11'($urandom_range(1, 12));
                     rows = 11'($urandom_range(0, 6)); end
            3: begin thr  = 11'($urandom_range(40, 120));
                     cols = 11'd2; rows = 11'd5; end
            4: begin thr  = 11'($urandom_range(0, 255));
                     cols = 11'($urandom_range(1, 16));
                     rows = 11'd1; end
            default: begin thr  = 11'($urandom_range(0, 255));
                     cols = 11'($urandom_range(1, 8));
                     rows = 11'($urandom_range(1, 6)); end
         endcase
         apply_setting(thr, cols, rows);
         // last part of the run goes without idling
         if (k == RANDOM_SETTINGS - 1) begin
            sender_gap_pct = 0;
            rsp_stall_pct  = 0;
         end else begin
            sender_gap_pct = $urandom_range(5, 30);
            rsp_stall_pct  = $urandom_range(5, 30);
         end
         for (int i = 0; i < PIXELS_PER_SET; i++) begin
            if ($urandom_range(1, 100) <= 12) begin
               pix = rand_pixel();
            end else begin
               if ($urandom_range(1, 100) <= 35) run_fg = !run_fg;
               pix = make_pixel(run_fg);
            end
            send_pixel(pix);
         end
         drain();
      end

      $display("covered %0d pixel transfers over %0d register settings, %0d runs reported",
               pixels_sent, settings_used, segments_checked);
      $display("included a long result stall, clamped sizes and size changes mid-frame");
      if (check_failures == 0 && results_pending == 0) begin
         $display("tb_background_subtract_run_blob_segmenter_core: done, clean");
      end else begin
         $display("tb_background_subtract_run_blob_segmenter_core: done, errors");
      end
      $finish;
   end

endmodule
